// File: hdl/bgc_pkg.sv
package bgc_pkg;

  // Gesture event codes reported with every result beat.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_WRAP   = 3'd2;
  localparam logic [2:0] EV_UP     = 3'd3;
  localparam logic [2:0] EV_SELECT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;
  localparam logic [1:0] REG_ENTRIES  = 2'd3;

  // Values the configuration registers take at reset.
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd15;
  localparam logic [11:0] WINDOW_RESET   = 12'd200;
  localparam logic [15:0] HOLD_RESET     = 16'd1500;
  localparam logic [5:0]  ENTRIES_RESET  = 6'd12;

  // Default menu size limit.
  localparam int MAX_ENTRIES_DEFAULT = 32;

  // The cursor register cannot address more than this many entries.
  localparam int CURSOR_LIMIT = 32;

endpackage

// File: hdl/button_gesture_cursor.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------
// input    | in_valid / in_stall    | button_pressed
// output   | out_valid / out_stall  | gesture_event, cursor_index
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every input beat gives exactly one output beat, via the input and result registers.
// One beat is taken every clock unless the output stalls; the input and result registers
// are the only two stages, and a tick updates the state as it enters the result register.
// Reset (rst, synchronous) clears the tick counter, all timers and the cursor,
// and loads the default configuration.
// A stall on the output holds the result; the input stalls only when both stages are full.
module button_gesture_cursor
  import bgc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        button_pressed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  gesture_event,
  output logic [4:0]  cursor_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ENTRY_LIMIT = (MAX_ENTRIES < CURSOR_LIMIT) ? MAX_ENTRIES : CURSOR_LIMIT;

  // Configuration registers.
  logic [7:0]  debounce_ms;
  logic [11:0] double_window_ms;
  logic [15:0] hold_ms;
  logic [5:0]  entry_count;

  // Gesture state.
  logic [31:0] now_ms;
  logic [31:0] last_edge_ms;
  logic [31:0] window_start_ms;
  logic [31:0] hold_start_ms;
  logic        window_active;
  logic        double_seen;
  logic        prev_level;
  logic        after_select;
  logic [4:0]  cursor;

  // Input stage.
  logic        in_full;
  logic        level;

  logic        advance;
  logic        work;

  // Next values.
  logic        edge_seen;
  logic        edge_taken;
  logic [31:0] last_edge_ms_next;
  logic [31:0] window_start_ms_next;
  logic [31:0] hold_base;
  logic [31:0] hold_start_ms_next;
  logic        win_open;
  logic        window_active_next;
  logic        dbl;
  logic        double_seen_next;
  logic        expire;
  logic        hold_fire;
  logic [5:0]  entries_eff;
  logic [4:0]  last_entry;
  logic [4:0]  cursor_next;
  logic        after_select_next;
  logic [2:0]  event_next;

  assign cfg_ready = 1'b1;

  // The result stage moves when it is empty or its beat is taken.
  assign advance  = !(out_valid && out_stall);
  assign work     = in_full && advance;
  assign in_stall = in_full && !advance;

  // Configuration writes, truncated to register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_RESET;
      double_window_ms <= WINDOW_RESET;
      hold_ms          <= HOLD_RESET;
      entry_count      <= ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_ms      <= cfg_data[7:0];
        REG_WINDOW:   double_window_ms <= cfg_data[11:0];
        REG_HOLD:     hold_ms          <= cfg_data;
        REG_ENTRIES:  entry_count      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      level <= button_pressed;
    end
  end

  // Press edge and debounce.
  always_comb begin
    edge_seen  = level && !prev_level;
    edge_taken = edge_seen && ((now_ms - last_edge_ms) > {24'd0, debounce_ms});
    hold_base  = edge_seen ? now_ms : hold_start_ms;
    last_edge_ms_next    = edge_taken ? now_ms : last_edge_ms;
    window_start_ms_next = (edge_taken && !window_active) ? now_ms : window_start_ms;
    win_open = window_active || edge_taken;
    dbl      = edge_taken ? window_active : double_seen;
  end

  // Effective menu size: zero counts as one, large values are clamped.
  always_comb begin
    entries_eff = entry_count;
    if (entry_count == 6'd0) begin
      entries_eff = 6'd1;
    end
    if (entry_count > 6'(ENTRY_LIMIT)) begin
      entries_eff = 6'(ENTRY_LIMIT);
    end
    last_entry = 5'(entries_eff - 6'd1);
  end

  // Window expiry moves the cursor; a hold select overrides the event.
  always_comb begin
    expire             = win_open &&
                         ((now_ms - window_start_ms_next) > {20'd0, double_window_ms});
    cursor_next        = cursor;
    after_select_next  = after_select;
    event_next         = EV_NONE;
    window_active_next = win_open;
    double_seen_next   = dbl;
    hold_start_ms_next = hold_base;
    if (expire) begin
      window_active_next = 1'b0;
      if (!dbl) begin
        if ((cursor >= last_entry) || after_select) begin
          cursor_next       = 5'd0;
          after_select_next = 1'b0;
          event_next        = EV_WRAP;
        end else begin
          cursor_next = cursor + 5'd1;
          event_next  = EV_DOWN;
        end
      end else begin
        if (cursor != 5'd0) begin
          cursor_next = cursor - 5'd1;
        end
        event_next = EV_UP;
      end
    end
    hold_fire = level && ((now_ms - hold_base) > {16'd0, hold_ms});
    if (hold_fire) begin
      event_next         = EV_SELECT;
      after_select_next  = 1'b1;
      window_active_next = 1'b0;
      hold_start_ms_next = now_ms;
    end
  end

  // State update, once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms          <= 32'd0;
      last_edge_ms    <= 32'd0;
      window_start_ms <= 32'd0;
      hold_start_ms   <= 32'd0;
      window_active   <= 1'b0;
      double_seen     <= 1'b0;
      prev_level      <= 1'b0;
      after_select    <= 1'b0;
      cursor          <= 5'd0;
    end else if (work) begin
      now_ms          <= now_ms + 32'd1;
      last_edge_ms    <= last_edge_ms_next;
      window_start_ms <= window_start_ms_next;
      hold_start_ms   <= hold_start_ms_next;
      window_active   <= window_active_next;
      double_seen     <= double_seen_next;
      prev_level      <= level;
      after_select    <= after_select_next;
      cursor          <= cursor_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      gesture_event <= event_next;
      cursor_index  <= cursor_next;
    end
  end

endmodule
